### hdl/seq_keyed_packet_buffer_macros.svh
// Assertion helpers shared by the buffer modules.
// Both expect clk and arst_n in the scope where they are used.
`ifndef SEQ_KEYED_PACKET_BUFFER_MACROS_SVH
`define SEQ_KEYED_PACKET_BUFFER_MACROS_SVH

// Same-cycle implication, off during reset.
`define SKPB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset.
`define SKPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/skpb_pkg.sv
package skpb_pkg;

	localparam int KEY_W = 32;
	localparam int HANDLE_W = 32;
	localparam int LIMIT_W = 7;
	localparam int OCC_W = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	// Operation codes
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_FIND = 2'd1;
	localparam logic [1:0] FUNC_ERASE = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [KEY_W-1:0] seq_num;
		logic [HANDLE_W-1:0] packet_handle;
		logic packet_kind;
	} req_item_t;

	typedef struct packed {
		logic hit;
		logic [HANDLE_W-1:0] found_handle;
		logic found_kind;
		logic evicted;
		logic [KEY_W-1:0] evicted_seq;
		logic [OCC_W-1:0] occupancy;
		logic full_res;
	} rsp_item_t;

	// One stored entry of the table memory
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HANDLE_W-1:0] handle;
		logic kind;
	} entry_t;

	// Status of a finished scan
	typedef struct packed {
		logic done;
		logic match_found;
		logic min_found;
		logic free_found;
	} scan_flags_t;

	// Write-back command to the table
	typedef struct packed {
		logic wr_en;
		logic clr_en;
	} wb_ctrl_t;

endpackage

### hdl/skpb_table.sv
`include "seq_keyed_packet_buffer_macros.svh"

module skpb_table
	import skpb_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int AW = 6
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [KEY_W-1:0] skey,
	input wb_ctrl_t wb,
	input logic [AW-1:0] wr_addr,
	input entry_t wr_data,
	input logic [AW-1:0] clr_addr,
	output scan_flags_t flags,
	output logic [AW-1:0] match_addr,
	output entry_t match_ent,
	output logic [AW-1:0] min_addr,
	output logic [KEY_W-1:0] min_key,
	output logic [AW-1:0] free_addr
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	entry_t mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] valid_d;

	logic [KEY_W-1:0] skey_q;
	logic [AW-1:0] rd_addr_q;
	logic issue_q;

	entry_t rd_data_s1;
	logic vld_s1;
	logic [AW-1:0] addr_s1;
	logic act_s1;
	logic last_s1;

	logic done_q;
	logic match_found_q;
	logic min_found_q;
	logic free_found_q;
	logic [AW-1:0] match_addr_q;
	entry_t match_ent_q;
	logic [AW-1:0] min_addr_q;
	logic [KEY_W-1:0] min_key_q;
	logic [AW-1:0] free_addr_q;

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wb.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue_q) begin
			rd_data_s1 <= mem[rd_addr_q];
		end
	end

	// Valid bits: clear first so a set at the same address wins
	always_comb begin
		valid_d = valid_q;
		if (wb.clr_en) begin
			valid_d[clr_addr] = 1'b0;
		end
		if (wb.wr_en) begin
			valid_d[wr_addr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Issue reads over all addresses, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			rd_addr_q <= '0;
			act_s1 <= 1'b0;
			last_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			addr_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			act_s1 <= issue_q;
			last_s1 <= issue_q && (rd_addr_q == LAST_ADDR);
			vld_s1 <= valid_q[rd_addr_q];
			addr_s1 <= rd_addr_q;
			done_q <= act_s1 && last_s1;
			if (start) begin
				issue_q <= 1'b1;
				rd_addr_q <= '0;
			end else if (issue_q) begin
				if (rd_addr_q == LAST_ADDR) begin
					issue_q <= 1'b0;
				end else begin
					rd_addr_q <= rd_addr_q + AW'(1);
				end
			end
		end
	end

	// Latch the search key
	always_ff @(posedge clk) begin
		if (start) begin
			skey_q <= skey;
		end
	end

	// Accumulate first match, lowest key and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			min_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (start) begin
			match_found_q <= 1'b0;
			min_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (act_s1) begin
			if (vld_s1 && !match_found_q && (rd_data_s1.key == skey_q)) begin
				match_found_q <= 1'b1;
			end
			if (vld_s1 && (!min_found_q || (rd_data_s1.key < min_key_q))) begin
				min_found_q <= 1'b1;
			end
			if (!vld_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// Payload of the accumulators
	always_ff @(posedge clk) begin
		if (act_s1) begin
			if (vld_s1 && !match_found_q && (rd_data_s1.key == skey_q)) begin
				match_addr_q <= addr_s1;
				match_ent_q <= rd_data_s1;
			end
			if (vld_s1 && (!min_found_q || (rd_data_s1.key < min_key_q))) begin
				min_addr_q <= addr_s1;
				min_key_q <= rd_data_s1.key;
			end
			if (!vld_s1 && !free_found_q) begin
				free_addr_q <= addr_s1;
			end
		end
	end

	assign flags = '{done: done_q, match_found: match_found_q,
		min_found: min_found_q, free_found: free_found_q};
	assign match_addr = match_addr_q;
	assign match_ent = match_ent_q;
	assign min_addr = min_addr_q;
	assign min_key = min_key_q;
	assign free_addr = free_addr_q;

	`SKPB_ASSERT_NOW(a_start_idle, start, !issue_q && !act_s1, "scan started while busy")
	`SKPB_ASSERT_NOW(a_wb_idle, wb.wr_en || wb.clr_en, !issue_q && !act_s1,
		"table written during a scan")
	`SKPB_ASSERT_NEXT(a_done_after_last, act_s1 && last_s1, done_q, "scan end not flagged")

endmodule

### hdl/seq_keyed_packet_buffer.sv
// Sequence-keyed packet buffer with lowest-sequence eviction.
// Request channel (req_valid/req_stall/req): one item asks for insert, find
// or erase of a 32-bit sequence key. An item is taken when req_valid is high
// and req_stall is low; req_stall is high while an item or a trim is at work.
// Response channel (rsp_valid/rsp_stall/rsp): exactly one item per request,
// with hit, found handle and kind, eviction report, occupancy and full flag.
// The response sits in an output register; a new request is taken while it
// waits for the receiver, and rsp holds steady while rsp_stall is high.
// Config channel (cfg_valid/cfg_ready/cfg_data): the capacity limit, taken
// only while idle. A lower limit evicts the lowest keys, one scan each,
// before requests are taken again; these evictions give no response.
// Each request reads every table entry through the one read port of the
// table memory, one entry per cycle. The next request is taken only once
// the response of the last one is in the output register. A trim eviction
// likewise reads every table entry for each evicted entry.
// Reset (arst_n low) empties the table at once and sets the limit to 64.
`include "seq_keyed_packet_buffer_macros.svh"

module seq_keyed_packet_buffer
	import skpb_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_item_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_item_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [LIMIT_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_OUT = 5'b00100,
		ST_TRIM = 5'b01000,
		ST_TSCAN = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	req_item_t item_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;

	logic hit_q;
	logic [HANDLE_W-1:0] fh_q;
	logic fk_q;
	logic ev_q;
	logic [KEY_W-1:0] evk_q;

	logic rsp_valid_q;
	rsp_item_t rsp_q;

	logic req_acc;
	logic cfg_acc;
	logic out_free;
	logic start;

	logic [LW-1:0] limit_ext;
	logic [LW-1:0] eff_limit;
	logic [LW-1:0] count_ext;
	logic full_now;
	logic trim_need;

	scan_flags_t flags;
	logic [AW-1:0] match_addr;
	entry_t match_ent;
	logic [AW-1:0] min_addr;
	logic [KEY_W-1:0] min_key;
	logic [AW-1:0] free_addr;

	wb_ctrl_t wb;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] clr_addr;
	entry_t wr_data;

	logic item_done;
	logic evict;
	logic match_eff;
	logic ins_new;
	logic hit_d;

	// Handshakes
	assign req_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Effective limit and fullness
	always_comb begin
		limit_ext = LW'(limit_q);
		eff_limit = (limit_ext > DEPTH_L) ? DEPTH_L : limit_ext;
		count_ext = LW'(count_q);
		full_now = (count_ext >= eff_limit);
		trim_need = (count_ext > eff_limit);
	end

	assign start = req_acc || ((state_q == ST_TRIM) && trim_need);
	assign item_done = (state_q == ST_SCAN) && flags.done;
	assign wr_data = '{key: item_q.seq_num, handle: item_q.packet_handle,
		kind: item_q.packet_kind};

	// Decide the write-back at the end of a scan
	always_comb begin
		wb = '0;
		wr_addr = match_addr;
		clr_addr = min_addr;
		evict = 1'b0;
		match_eff = 1'b0;
		ins_new = 1'b0;
		hit_d = 1'b0;
		count_d = count_q;
		if (item_done) begin
			unique case (item_q.func)
				FUNC_INSERT: begin
					evict = full_now && flags.min_found;
					match_eff = flags.match_found && !(evict && (match_addr == min_addr));
					wb.clr_en = evict;
					if (match_eff) begin
						wb.wr_en = 1'b1;
						wr_addr = match_addr;
					end else if (flags.free_found && (!evict || (free_addr < min_addr))) begin
						wb.wr_en = 1'b1;
						ins_new = 1'b1;
						wr_addr = free_addr;
					end else if (evict) begin
						wb.wr_en = 1'b1;
						ins_new = 1'b1;
						wr_addr = min_addr;
					end
					count_d = count_q + CW'(ins_new) - CW'(evict);
				end
				FUNC_FIND: begin
					hit_d = flags.match_found;
				end
				FUNC_ERASE: begin
					hit_d = flags.match_found;
					wb.clr_en = flags.match_found;
					clr_addr = match_addr;
					count_d = count_q - CW'(flags.match_found);
				end
				default: begin
				end
			endcase
		end else if ((state_q == ST_TSCAN) && flags.done && flags.min_found) begin
			wb.clr_en = 1'b1;
			clr_addr = min_addr;
			count_d = count_q - CW'(1);
		end
	end

	// Sequence one item or one trim step at a time
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_acc) begin
					state_d = ST_TRIM;
				end else if (req_acc) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (flags.done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TRIM: begin
				state_d = trim_need ? ST_TSCAN : ST_IDLE;
			end
			ST_TSCAN: begin
				if (flags.done) begin
					state_d = flags.min_found ? ST_TRIM : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			limit_q <= LIMIT_RESET;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_acc) begin
				limit_q <= cfg_data;
			end
			if ((state_q == ST_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item and its scan results
	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req;
		end
		if (item_done) begin
			hit_q <= hit_d;
			fh_q <= (item_q.func == FUNC_FIND && flags.match_found) ?
				match_ent.handle : '0;
			fk_q <= (item_q.func == FUNC_FIND && flags.match_found) ?
				match_ent.kind : 1'b0;
			ev_q <= evict;
			evk_q <= evict ? min_key : '0;
		end
		if ((state_q == ST_OUT) && out_free) begin
			rsp_q <= '{hit: hit_q, found_handle: fh_q, found_kind: fk_q,
				evicted: ev_q, evicted_seq: evk_q, occupancy: OCC_W'(count_q),
				full_res: full_now};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	skpb_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.skey(req.seq_num),
		.wb(wb),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.clr_addr(clr_addr),
		.flags(flags),
		.match_addr(match_addr),
		.match_ent(match_ent),
		.min_addr(min_addr),
		.min_key(min_key),
		.free_addr(free_addr)
	);

	`SKPB_ASSERT_NOW(a_count_bound, 1'b1, count_ext <= DEPTH_L, "occupancy above depth")
	`SKPB_ASSERT_NEXT(a_req_to_scan, req_acc, state_q == ST_SCAN, "accepted item not scanned")
	`SKPB_ASSERT_NOW(a_done_in_scan, flags.done,
		(state_q == ST_SCAN) || (state_q == ST_TSCAN), "scan result with no scan pending")
	`SKPB_ASSERT_NEXT(a_rsp_loaded, (state_q == ST_OUT) && out_free, rsp_valid,
		"response not presented")
	`SKPB_ASSERT_NOW(a_trim_no_rsp, (state_q == ST_TSCAN) && flags.done,
		state_d != ST_OUT, "trim produced a response")

endmodule

### verif/seq_buffer_checker.sv
module seq_buffer_checker
	import skpb_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_item_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_item_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [LIMIT_W-1:0] cfg_data,
	output int fail_count,
	output int pending,
	output int req_count,
	output int evict_count,
	output int hit_count,
	output int trim_count
);

	// Shadow copy of the table and the limit register
	logic tbl_valid [DEPTH];
	logic [KEY_W-1:0] tbl_key [DEPTH];
	logic [HANDLE_W-1:0] tbl_handle [DEPTH];
	logic tbl_kind [DEPTH];
	int unsigned tbl_count;
	logic [LIMIT_W-1:0] cap_limit;
	rsp_item_t expected_rsp_q [$];
	int n_fail;
	int n_req;
	int n_evict;
	int n_hit;
	int n_trim;

	assign fail_count = n_fail;
	assign req_count = n_req;
	assign evict_count = n_evict;
	assign hit_count = n_hit;
	assign trim_count = n_trim;

	// Limits above the table depth act as the full depth
	function automatic int unsigned kept_limit();
		return (cap_limit > DEPTH) ? DEPTH : cap_limit;
	endfunction

	function automatic int slot_of(input logic [KEY_W-1:0] key);
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_key[i] == key)
				return i;
		return -1;
	endfunction

	// Remove the entry with the lowest key; report nothing on an empty table
	function automatic bit drop_lowest(output logic [KEY_W-1:0] key);
		int best;
		best = -1;
		key = '0;
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && (best < 0 || tbl_key[i] < tbl_key[best]))
				best = i;
		if (best < 0)
			return 1'b0;
		tbl_valid[best] = 1'b0;
		if (tbl_count > 0)
			tbl_count--;
		key = tbl_key[best];
		return 1'b1;
	endfunction

	// Apply one request to the shadow table and build its result
	function automatic rsp_item_t predict_result(input req_item_t it);
		rsp_item_t r;
		int idx;
		logic [KEY_W-1:0] gone_key;
		r = '0;
		case (it.func)
			FUNC_INSERT: begin
				// a full table loses its lowest key first, even on an overwrite
				if (tbl_count >= kept_limit() && drop_lowest(gone_key)) begin
					r.evicted = 1'b1;
					r.evicted_seq = gone_key;
				end
				idx = slot_of(it.seq_num);
				if (idx < 0) begin
					for (int i = 0; i < DEPTH; i++)
						if (!tbl_valid[i]) begin
							idx = i;
							break;
						end
					if (idx >= 0) begin
						tbl_valid[idx] = 1'b1;
						tbl_count++;
					end
				end
				if (idx >= 0) begin
					tbl_key[idx] = it.seq_num;
					tbl_handle[idx] = it.packet_handle;
					tbl_kind[idx] = it.packet_kind;
				end
			end
			FUNC_FIND: begin
				idx = slot_of(it.seq_num);
				if (idx >= 0) begin
					r.hit = 1'b1;
					r.found_handle = tbl_handle[idx];
					r.found_kind = tbl_kind[idx];
				end
			end
			FUNC_ERASE: begin
				idx = slot_of(it.seq_num);
				if (idx >= 0) begin
					r.hit = 1'b1;
					tbl_valid[idx] = 1'b0;
					if (tbl_count > 0)
						tbl_count--;
				end
			end
			default: begin
				// unused code leaves the table alone
			end
		endcase
		r.occupancy = OCC_W'(tbl_count);
		r.full_res = (tbl_count >= kept_limit());
		return r;
	endfunction

	task automatic compare_field(input string fname, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, want_v, got_v);
			n_fail++;
		end
	endtask

	// Track limit writes, check results, then queue the prediction for a new item
	always @(posedge clk or negedge arst_n) begin : track
		rsp_item_t want;
		logic [KEY_W-1:0] gone_key;
		if (!arst_n) begin
			cap_limit = LIMIT_RESET;
			tbl_count = 0;
			for (int i = 0; i < DEPTH; i++)
				tbl_valid[i] = 1'b0;
			expected_rsp_q.delete();
			n_fail = 0;
			n_req = 0;
			n_evict = 0;
			n_hit = 0;
			n_trim = 0;
		end else begin
			// trim the lowest keys down to a new limit
			if (cfg_valid && cfg_ready) begin
				cap_limit = cfg_data;
				while (tbl_count > kept_limit() && drop_lowest(gone_key))
					n_trim++;
			end
			// compare a delivered item with the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: result with none expected, expected nothing actual %p",
						$time, rsp);
					n_fail++;
				end else begin
					want = expected_rsp_q.pop_front();
					compare_field("hit", want.hit, rsp.hit);
					compare_field("found_handle", want.found_handle, rsp.found_handle);
					compare_field("found_kind", want.found_kind, rsp.found_kind);
					compare_field("evicted", want.evicted, rsp.evicted);
					compare_field("evicted_seq", want.evicted_seq, rsp.evicted_seq);
					compare_field("occupancy", want.occupancy, rsp.occupancy);
					compare_field("full_res", want.full_res, rsp.full_res);
					n_hit += want.hit;
					n_evict += want.evicted;
				end
			end
			// predict an accepted request
			if (req_valid && !req_stall) begin
				expected_rsp_q.push_back(predict_result(req));
				n_req++;
			end
		end
		pending <= expected_rsp_q.size();
	end

endmodule

### verif/tb.sv
module tb;
	import skpb_pkg::*;

	localparam int DEPTH = 64;
	// slowest run comes from stalled results, long gaps and full trims
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int ITEMS_PER_PHASE = 192;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_item_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_item_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int req_count;
	int evict_count;
	int hit_count;
	int trim_count;
	int cycle_count = 0;
	int limit_writes = 0;
	logic [KEY_W-1:0] key_pool [$];

	seq_keyed_packet_buffer #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	seq_buffer_checker #(
		.DEPTH(DEPTH)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.req_count(req_count),
		.evict_count(evict_count),
		.hit_count(hit_count),
		.trim_count(trim_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stall the result side in stretches: none, light, heavy, occasional
	initial begin : stall_pattern
		int mode;
		int run_len;
		forever begin
			mode = $urandom_range(0, 3);
			run_len = $urandom_range(20, 300);
			repeat (run_len) begin
				@(posedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 1) == 1);
					2: rsp_stall <= ($urandom_range(0, 7) != 0);
					default: rsp_stall <= ($urandom_range(0, 5) == 0);
				endcase
			end
		end
	end

	function automatic req_item_t mk(input logic [1:0] f, input logic [KEY_W-1:0] k,
			input logic [HANDLE_W-1:0] h, input logic kd);
		req_item_t it;
		it.func = f;
		it.seq_num = k;
		it.packet_handle = h;
		it.packet_kind = kd;
		return it;
	endfunction

	// Hold the item until the block takes it; valid stays high afterwards
	task automatic send_req(input req_item_t it);
		req <= it;
		req_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (req_stall);
	endtask

	// Drop valid and wait for every outstanding result, then let the block settle
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_writes++;
	endtask

	// Keys cluster near both ends of the range and scatter in between
	function automatic void refill_pool(input int n);
		key_pool.delete();
		repeat (n) begin
			case ($urandom_range(0, 3))
				0: key_pool.push_back(KEY_W'($urandom_range(0, 300)));
				1: key_pool.push_back(32'hFFFF_FFFF - KEY_W'($urandom_range(0, 300)));
				default: key_pool.push_back($urandom);
			endcase
		end
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		logic [KEY_W-1:0] k;
		sel = $urandom_range(0, 99);
		k = key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (sel < 85)
			return k;
		if (sel < 95)
			return ($urandom_range(0, 1) == 1) ? k + KEY_W'(1) : k - KEY_W'(1);
		return $urandom;
	endfunction

	function automatic req_item_t random_req();
		req_item_t it;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			it.func = FUNC_INSERT;
		else if (sel < 70)
			it.func = FUNC_FIND;
		else if (sel < 95)
			it.func = FUNC_ERASE;
		else
			it.func = FUNC_NONE;
		it.seq_num = pick_key();
		it.packet_handle = $urandom;
		it.packet_kind = 1'($urandom_range(0, 1));
		return it;
	endfunction

	initial begin : stimulus
		logic [LIMIT_W-1:0] phase_lim [9];
		int burst_left;
		int gap;
		phase_lim = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd17, 7'd90, 7'd2, 7'd3, 7'd64};
		phase_lim[6] = LIMIT_W'($urandom_range(2, 63));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extreme keys, overwrite, unused code, repeated erase
		send_req(mk(FUNC_FIND, 32'h0, 32'h0, 1'b0));
		send_req(mk(FUNC_ERASE, 32'hFFFF_FFFF, 32'h0, 1'b0));
		send_req(mk(FUNC_INSERT, 32'h0, 32'h0, 1'b0));
		send_req(mk(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_req(mk(FUNC_FIND, 32'h0, 32'hFFFF_FFFF, 1'b1));
		send_req(mk(FUNC_FIND, 32'hFFFF_FFFF, 32'h0, 1'b0));
		send_req(mk(FUNC_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 1'b0));
		send_req(mk(FUNC_FIND, 32'hFFFF_FFFF, 32'h0, 1'b0));
		send_req(mk(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_req(mk(FUNC_ERASE, 32'h0, 32'h0, 1'b0));
		send_req(mk(FUNC_ERASE, 32'h0, 32'h0, 1'b0));
		send_req(mk(FUNC_INSERT, 32'd10, 32'h1, 1'b0));
		send_req(mk(FUNC_INSERT, 32'd20, 32'h2, 1'b1));
		send_req(mk(FUNC_INSERT, 32'd30, 32'h3, 1'b0));

		// lower the limit to trim the two lowest keys
		drain();
		write_limit(7'd2);
		send_req(mk(FUNC_FIND, 32'd10, 32'h0, 1'b0));
		// full table, key present and lowest: evict it, then store afresh
		send_req(mk(FUNC_INSERT, 32'd30, 32'h33, 1'b1));
		// full table, key present but not lowest: evict the other, then overwrite
		send_req(mk(FUNC_INSERT, 32'hFFFF_FFFF, 32'h44, 1'b1));
		send_req(mk(FUNC_FIND, 32'hFFFF_FFFF, 32'h0, 1'b0));

		// zero limit: trim to empty, then each insert after the first replaces the single entry
		drain();
		write_limit(7'd0);
		send_req(mk(FUNC_INSERT, 32'd7, 32'h77, 1'b0));
		send_req(mk(FUNC_INSERT, 32'd8, 32'h88, 1'b1));
		send_req(mk(FUNC_FIND, 32'd7, 32'h0, 1'b0));
		send_req(mk(FUNC_FIND, 32'd8, 32'h0, 1'b0));

		// random phases, one limit each, sender in bursts
		foreach (phase_lim[p]) begin
			drain();
			write_limit(phase_lim[p]);
			refill_pool($urandom_range(3, 100));
			burst_left = $urandom_range(1, 24);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_req(random_req());
				burst_left--;
				if ($urandom_range(0, 149) == 0) begin
					// hold off until every result is back
					drain();
				end else if (burst_left <= 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					if (gap > 0) begin
						req_valid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
			end
		end

		drain();
		$display("Covered %0d requests under %0d limit writes, zero and above-depth included.",
			req_count, limit_writes);
		$display("Saw %0d insert evictions, %0d find or erase hits, %0d entries trimmed.",
			evict_count, hit_count, trim_count);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
